/* hw/rtl/pcvr_pkg.sv */
// pcvr_pkg: widths, the word that travels down the pipeline and the saturation helper
// used by the front end, the divider steps and the back end of the contact velocity resolve unit; no dependencies
package pcvr_pkg;

  localparam int VW  = 32;  // velocity, signed q16.16
  localparam int NW  = 16;  // normal component, signed q2.14
  localparam int IW  = 31;  // inverse mass, unsigned q15.16
  localparam int EW  = 17;  // restitution, q1.16
  localparam int DVW = 36;  // velocity change magnitude
  localparam int QW  = 33;  // mass ratio quotient, q1.32 up to 1.0
  localparam int RW  = 32;  // divider remainder
  localparam int DW  = 40;  // per-axis velocity delta
  localparam int DIV_STEPS = 32;

  typedef logic [2:0][VW-1:0] vec3_t;
  typedef logic [2:0][NW-1:0] nrm3_t;

  // word between the front end, the divider steps and the back end
  typedef struct packed {
    vec3_t           v1;
    vec3_t           v2;
    nrm3_t           n;
    logic [DVW-1:0]  dv;
    logic [VW-1:0]   total;
    logic [RW-1:0]   rem;
    logic [QW-1:0]   quo;
    logic            applied;
    logic            swap;
  } pkt_t;

  function automatic logic [VW-1:0] sat32(input logic signed [DW+1:0] x);
    logic signed [DW+1:0] hi;
    logic signed [DW+1:0] lo;
    hi = (DW+2)'(signed'(33'sh0_7FFF_FFFF));
    lo = (DW+2)'(signed'(33'sh1_8000_0000));
    if (x > hi) begin
      return 32'h7FFF_FFFF;
    end else if (x < lo) begin
      return 32'h8000_0000;
    end else begin
      return x[VW-1:0];
    end
  endfunction

endpackage

/* hw/rtl/pcvr_ifs.sv */
// pcvr_in_if / pcvr_out_if: valid-ready channels of the contact velocity resolve unit
// standalone, no package dependency
interface pcvr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] vel_a_z;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;
  logic signed [31:0] vel_b_z;
  logic [30:0]        inv_mass_a;
  logic [30:0]        inv_mass_b;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [16:0]        bounce_factor;

  modport source (output valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
                  inv_mass_a, inv_mass_b, normal_x, normal_y, normal_z, bounce_factor,
                  input ready);
  modport sink (input valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
                inv_mass_a, inv_mass_b, normal_x, normal_y, normal_z, bounce_factor,
                output ready);
endinterface

interface pcvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_a_x;
  logic signed [31:0] new_a_y;
  logic signed [31:0] new_a_z;
  logic signed [31:0] new_b_x;
  logic signed [31:0] new_b_y;
  logic signed [31:0] new_b_z;
  logic               impulse_applied;
  logic               roles_swapped;

  modport source (output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
                  impulse_applied, roles_swapped, input ready);
  modport sink (input valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
                impulse_applied, roles_swapped, output ready);
endinterface

/* hw/rtl/pcvr_front.sv */
// pcvr_front: four stages - role select, dot products, dot sum, impulse magnitude
// and divider seed; uses pcvr_pkg and pcvr_in_if
module pcvr_front (
  input  logic          clk,
  input  logic          rst_n,
  pcvr_in_if.sink       in_ch,
  output logic          dn_valid,
  input  logic          dn_ready,
  output pcvr_pkg::pkt_t dn_pkt
);
  import pcvr_pkg::*;

  typedef struct packed {
    vec3_t              v1;
    vec3_t              v2;
    nrm3_t              n;
    logic [IW-1:0]      inv1;
    logic [VW-1:0]      total;
    logic [EW-1:0]      e;
    logic               swap;
    logic [2:0][47:0]   prod;
    logic signed [49:0] sv30;
    logic               applied;
  } fr_t;

  fr_t  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  pkt_t d_r, d_nxt;
  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  vec3_t va, vb;
  logic  a_zero, b_absent, sw;
  logic signed [49:0] sv16;
  logic [35:0]        neg;
  logic [52:0]        mag;
  logic               q32;

  assign rdy_d = !vd_r || dn_ready;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_ch.ready = rdy_a;

  // stage a: pick the leading particle
  always_comb begin
    va[0] = in_ch.vel_a_x;
    va[1] = in_ch.vel_a_y;
    va[2] = in_ch.vel_a_z;
    vb[0] = in_ch.vel_b_x;
    vb[1] = in_ch.vel_b_y;
    vb[2] = in_ch.vel_b_z;
    a_zero   = (va == '0);
    b_absent = (vb == '0) && (in_ch.inv_mass_b == '0);
    sw       = a_zero && !b_absent;
    a_nxt       = '0;
    a_nxt.v1    = sw ? vb : va;
    a_nxt.v2    = sw ? va : vb;
    a_nxt.n[0]  = in_ch.normal_x;
    a_nxt.n[1]  = in_ch.normal_y;
    a_nxt.n[2]  = in_ch.normal_z;
    a_nxt.inv1  = sw ? in_ch.inv_mass_b : in_ch.inv_mass_a;
    a_nxt.total = {1'b0, in_ch.inv_mass_a} + {1'b0, in_ch.inv_mass_b};
    a_nxt.e     = in_ch.bounce_factor;
    a_nxt.swap  = sw;
  end

  // stage b: per-axis products
  always_comb begin
    b_nxt = a_r;
    for (int k = 0; k < 3; k++) begin
      b_nxt.prod[k] = 48'($signed(a_r.v1[k]) * $signed(a_r.n[k]));
    end
  end

  // stage c: separating velocity and path decision
  always_comb begin
    c_nxt = b_r;
    c_nxt.sv30 = 50'($signed(b_r.prod[0])) + 50'($signed(b_r.prod[1]))
               + 50'($signed(b_r.prod[2]));
    c_nxt.applied = (c_nxt.sv30 <= 50'sd0) && (b_r.total != '0);
  end

  // stage d: velocity change magnitude, divider seed
  always_comb begin
    sv16 = c_r.sv30 >>> 14;
    neg  = 36'(-sv16);
    mag  = 53'(neg[34:0]) * 53'(18'd65536 + 18'(c_r.e));
    q32  = ({1'b0, c_r.inv1} == c_r.total);
    d_nxt         = '0;
    d_nxt.v1      = c_r.v1;
    d_nxt.v2      = c_r.v2;
    d_nxt.n       = c_r.n;
    d_nxt.dv      = mag[DVW+15:16];
    d_nxt.total   = c_r.total;
    d_nxt.rem     = q32 ? '0 : {1'b0, c_r.inv1};
    d_nxt.quo     = {32'b0, q32};
    d_nxt.applied = c_r.applied;
    d_nxt.swap    = c_r.swap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_ch.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_ch.valid) a_r <= a_nxt;
    if (rdy_b && va_r) b_r <= b_nxt;
    if (rdy_c && vb_r) c_r <= c_nxt;
    if (rdy_d && vc_r) d_r <= d_nxt;
  end

  assign dn_valid = vd_r;
  assign dn_pkt   = d_r;

endmodule

/* hw/rtl/pcvr_div_step.sv */
// pcvr_div_step: one registered restoring-division step, one quotient bit
// uses pcvr_pkg
module pcvr_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pcvr_pkg::pkt_t up_pkt,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pcvr_pkg::pkt_t dn_pkt
);
  import pcvr_pkg::*;

  pkt_t        pkt_r, pkt_nxt;
  logic        vld_r;
  logic [RW:0] rem2;
  logic [RW:0] diff;
  logic        ge;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    rem2 = {up_pkt.rem, 1'b0};
    diff = rem2 - {1'b0, up_pkt.total};
    ge   = (rem2 >= {1'b0, up_pkt.total});
    pkt_nxt     = up_pkt;
    pkt_nxt.rem = ge ? diff[RW-1:0] : rem2[RW-1:0];
    pkt_nxt.quo = {up_pkt.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) pkt_r <= pkt_nxt;
  end

  assign dn_valid = vld_r;
  assign dn_pkt   = pkt_r;

endmodule

/* hw/rtl/pcvr_back.sv */
// pcvr_back: mass split products, ratio scaling, per-axis deltas, saturating update
// and the output register; uses pcvr_pkg and pcvr_out_if
module pcvr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pcvr_pkg::pkt_t up_pkt,
  pcvr_out_if.source     out_ch
);
  import pcvr_pkg::*;

  typedef struct packed {
    pkt_t                       p;
    logic [1:0][52:0]           ph;
    logic [1:0][51:0]           pl;
    logic [1:0][DVW:0]          m;
    logic [1:0][2:0][DW-1:0]    d;
  } be_t;

  typedef struct packed {
    vec3_t a;
    vec3_t b;
    logic  applied;
    logic  swap;
  } res_t;

  be_t  e_r, e_nxt, f_r, f_nxt, g_r, g_nxt;
  res_t h_r, h_nxt;
  logic ve_r, vf_r, vg_r, vh_r;
  logic rdy_e, rdy_f, rdy_g, rdy_h;

  logic [1:0][QW-1:0] r;
  logic [53:0]        msum;
  logic signed [53:0] dprod;
  vec3_t              n1, n2;

  assign rdy_h = !vh_r || out_ch.ready;
  assign rdy_g = !vg_r || rdy_h;
  assign rdy_f = !vf_r || rdy_g;
  assign rdy_e = !ve_r || rdy_f;
  assign up_ready = rdy_e;

  // stage e: ratios from one quotient, split products
  always_comb begin
    r[0] = up_pkt.quo;
    r[1] = 33'h1_0000_0000 - up_pkt.quo - 33'(up_pkt.rem != '0);
    e_nxt   = '0;
    e_nxt.p = up_pkt;
    for (int i = 0; i < 2; i++) begin
      e_nxt.ph[i] = 53'(up_pkt.dv) * 53'(r[i][32:16]);
      e_nxt.pl[i] = 52'(up_pkt.dv) * 52'(r[i][15:0]);
    end
  end

  // stage f: recombine to q16.16 share
  always_comb begin
    f_nxt = e_r;
    msum  = '0;
    for (int i = 0; i < 2; i++) begin
      msum = 54'(e_r.ph[i]) + 54'(e_r.pl[i] >> 16);
      f_nxt.m[i] = msum[DVW+16:16];
    end
  end

  // stage g: along-normal deltas
  always_comb begin
    g_nxt = f_r;
    dprod = '0;
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 3; k++) begin
        dprod = 54'($signed(f_r.p.n[k]) * $signed({1'b0, f_r.m[i]}));
        g_nxt.d[i][k] = DW'(dprod >>> 14);
      end
    end
  end

  // stage h: saturating update and role restore
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n1[k] = sat32(42'($signed(g_r.p.v1[k])) + 42'($signed(g_r.d[0][k])));
      n2[k] = sat32(42'($signed(g_r.p.v2[k])) - 42'($signed(g_r.d[1][k])));
      if (!g_r.p.applied) begin
        n1[k] = g_r.p.v1[k];
        n2[k] = g_r.p.v2[k];
      end
    end
    h_nxt.a       = g_r.p.swap ? n2 : n1;
    h_nxt.b       = g_r.p.swap ? n1 : n2;
    h_nxt.applied = g_r.p.applied;
    h_nxt.swap    = g_r.p.swap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else begin
      if (rdy_e) ve_r <= up_valid;
      if (rdy_f) vf_r <= ve_r;
      if (rdy_g) vg_r <= vf_r;
      if (rdy_h) vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && up_valid) e_r <= e_nxt;
    if (rdy_f && ve_r) f_r <= f_nxt;
    if (rdy_g && vf_r) g_r <= g_nxt;
    if (rdy_h && vg_r) h_r <= h_nxt;
  end

  assign out_ch.valid           = vh_r;
  assign out_ch.new_a_x         = h_r.a[0];
  assign out_ch.new_a_y         = h_r.a[1];
  assign out_ch.new_a_z         = h_r.a[2];
  assign out_ch.new_b_x         = h_r.b[0];
  assign out_ch.new_b_y         = h_r.b[1];
  assign out_ch.new_b_z         = h_r.b[2];
  assign out_ch.impulse_applied = h_r.applied;
  assign out_ch.roles_swapped   = h_r.swap;

  // divider leaves a proper remainder for every item that takes the impulse path
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && up_pkt.applied) |-> (up_pkt.rem < up_pkt.total))
    else $error("divider remainder not below total inverse mass");

  // pass-through items leave output A equal to the role-restored input
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_h && vg_r && !g_r.p.applied) |=>
      (h_r.a == ($past(g_r.p.swap) ? $past(g_r.p.v2) : $past(g_r.p.v1))))
    else $error("pass-through velocity altered");

  // a swapped pass-through word carries a particle A at rest
  a_swap_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (vh_r && h_r.swap && !h_r.applied) |-> (h_r.a == '0))
    else $error("roles swapped with particle A moving");

endmodule

/* hw/rtl/particle_contact_velocity_resolve_unit.sv */
// particle_contact_velocity_resolve_unit: top level of the two-particle contact resolver
// depends on pcvr_pkg, pcvr_ifs, pcvr_front, pcvr_div_step and pcvr_back
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    both velocities, inverse masses, normal, restitution
//   out_ch   out  valid/ready    both new velocities, impulse_applied, roles_swapped
//
// one word per cycle sustained while out_ch is ready
// the 32 one-bit steps of the mass ratio divider sit between
// 4 front stages and 4 back stages (the last is the output register)
// each stage holds its own valid bit and loads when empty or when its successor moves,
// so bubbles close up and input is taken while a result waits on out_ch
// synchronous active-low reset clears only the valid bits
module particle_contact_velocity_resolve_unit (
  input  logic        clk,
  input  logic        rst_n,
  pcvr_in_if.sink     in_ch,
  pcvr_out_if.source  out_ch
);
  import pcvr_pkg::*;

  // stage links: index 0 is the front end output, DIV_STEPS the divider output
  logic [DIV_STEPS:0] lnk_valid;
  logic [DIV_STEPS:0] lnk_ready;
  pkt_t               lnk_pkt [DIV_STEPS+1];

  // role select, dot product, impulse magnitude, divider seed
  pcvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (lnk_valid[0]),
    .dn_ready (lnk_ready[0]),
    .dn_pkt   (lnk_pkt[0])
  );

  // inverse mass ratio, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    pcvr_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lnk_valid[i]),
      .up_ready (lnk_ready[i]),
      .up_pkt   (lnk_pkt[i]),
      .dn_valid (lnk_valid[i+1]),
      .dn_ready (lnk_ready[i+1]),
      .dn_pkt   (lnk_pkt[i+1])
    );
  end

  // impulse shares, deltas, saturating update, output register
  pcvr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lnk_valid[DIV_STEPS]),
    .up_ready (lnk_ready[DIV_STEPS]),
    .up_pkt   (lnk_pkt[DIV_STEPS]),
    .out_ch   (out_ch)
  );

endmodule

/* tb/sv/pcvr_tb_ifs_note.sv */
// contact resolver testbench support: stimulus and result word types used by the bench top
// no dependencies; the bench takes the interfaces from pcvr_ifs.sv in the rtl as they are
package pcvr_tb_pkg;

  typedef struct packed {
    logic signed [31:0] va_x, va_y, va_z;
    logic signed [31:0] vb_x, vb_y, vb_z;
    logic [30:0]        ima, imb;
    logic signed [15:0] n_x, n_y, n_z;
    logic [16:0]        e;
  } contact_t;

  typedef struct packed {
    logic signed [31:0] a_x, a_y, a_z;
    logic signed [31:0] b_x, b_y, b_z;
    logic               applied;
    logic               swapped;
  } resolved_t;

endpackage

/* tb/sv/particle_contact_velocity_resolve_unit_tb.sv */
// self-checking bench for particle_contact_velocity_resolve_unit: directed table then
// random contacts, idling phases on both channels; depends on pcvr_ifs, pcvr_tb_pkg and the dut
module particle_contact_velocity_resolve_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcvr_tb_pkg::*;

  localparam int LATENCY   = 40;
  localparam int CYCLE_MAX = 400000;

  logic clk;
  logic rst_n;
  pcvr_in_if  in_ch ();
  pcvr_out_if out_ch ();

  particle_contact_velocity_resolve_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  resolved_t pending_velocities[$];
  int        mismatch_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // floor shift of a signed value
  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(a * r / 2^32), split so nothing overflows 64 bits
  function automatic longint unsigned scale_q32(longint unsigned a, longint unsigned r);
    longint unsigned rh;
    longint unsigned rl;
    rh = r >> 16;
    rl = r & 64'hFFFF;
    return (a * rh + ((a * rl) >> 16)) >> 16;
  endfunction

  // impulse resolution of one contact
  function automatic resolved_t resolve_contact(contact_t c);
    resolved_t r;
    longint va[3], vb[3], nv[3], v1[3], v2[3];
    longint unsigned inv1, inv2, total, dv, m1, m2;
    longint sv30, sv16, d1, d2;
    bit a_rest, b_absent, swap, applied;
    va = '{c.va_x, c.va_y, c.va_z};
    vb = '{c.vb_x, c.vb_y, c.vb_z};
    nv = '{c.n_x, c.n_y, c.n_z};
    a_rest   = (va[0] == 0 && va[1] == 0 && va[2] == 0);
    b_absent = (vb[0] == 0 && vb[1] == 0 && vb[2] == 0 && c.imb == 0);
    swap     = a_rest && !b_absent;
    applied  = 1'b0;
    if (swap) begin
      v1 = vb; v2 = va; inv1 = c.imb; inv2 = c.ima;
    end else begin
      v1 = va; v2 = vb; inv1 = c.ima; inv2 = c.imb;
    end
    sv30  = v1[0] * nv[0] + v1[1] * nv[1] + v1[2] * nv[2];
    total = longint'(c.ima) + longint'(c.imb);
    if (sv30 <= 0 && total != 0) begin
      applied = 1'b1;
      sv16 = floor_sh(sv30, 14);
      dv   = (longint'(-sv16) * (64'd65536 + c.e)) >> 16;
      m1   = scale_q32(dv, (inv1 << 32) / total);
      m2   = scale_q32(dv, (inv2 << 32) / total);
      for (int k = 0; k < 3; k++) begin
        d1 = floor_sh(nv[k] * longint'(m1), 14);
        d2 = floor_sh(nv[k] * longint'(m2), 14);
        v1[k] = clamp32(v1[k] + d1);
        v2[k] = clamp32(v2[k] - d2);
      end
      if (swap) begin
        vb = v1; va = v2;
      end else begin
        va = v1; vb = v2;
      end
    end
    r.a_x = va[0]; r.a_y = va[1]; r.a_z = va[2];
    r.b_x = vb[0]; r.b_y = vb[1]; r.b_z = vb[2];
    r.applied = applied;
    r.swapped = swap;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return $signed(32'($urandom_range(0, 32'h000F_FFFF))) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1, 32'h0004_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($signed(32'($urandom_range(0, 32768))) - 32768 + 16384);
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.va_x = rand_vel(); c.va_y = rand_vel(); c.va_z = rand_vel();
    c.vb_x = rand_vel(); c.vb_y = rand_vel(); c.vb_z = rand_vel();
    if ($urandom_range(0, 7) == 0) {c.va_x, c.va_y, c.va_z} = '0;
    c.ima = rand_mass();
    c.imb = rand_mass();
    if ($urandom_range(0, 9) == 0) begin
      {c.vb_x, c.vb_y, c.vb_z} = '0;
      c.imb = '0;
    end
    c.n_x = rand_comp(); c.n_y = rand_comp(); c.n_z = rand_comp();
    c.e = ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    return c;
  endfunction

  // directed rows; has_fixed marks rows whose expectation is typed in
  typedef struct {
    contact_t  c;
    bit        has_fixed;
    resolved_t fixed;
  } row_t;

  row_t directed_rows[$];

  function automatic contact_t mk(longint ax, ay, az, bx, by, bz, ma, mb,
                                  nx, ny, nz, e);
    contact_t c;
    c.va_x = ax; c.va_y = ay; c.va_z = az;
    c.vb_x = bx; c.vb_y = by; c.vb_z = bz;
    c.ima = ma; c.imb = mb;
    c.n_x = nx; c.n_y = ny; c.n_z = nz;
    c.e = e;
    return c;
  endfunction

  function automatic resolved_t passed(contact_t c, bit sw);
    resolved_t r;
    r = '{c.va_x, c.va_y, c.va_z, c.vb_x, c.vb_y, c.vb_z, 1'b0, sw};
    return r;
  endfunction

  task automatic add_row(contact_t c, bit fixed_ok, resolved_t fx);
    row_t r;
    r.c = c; r.has_fixed = fixed_ok; r.fixed = fx;
    directed_rows.push_back(r);
  endtask

  task automatic build_rows();
    contact_t c;
    // all zero: absent b, zero total mass, pass-through
    c = mk(0, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
    add_row(c, 1, passed(c, 0));
    // separating contact: positive dot product passes through
    c = mk(65536, 0, 0, 0, 0, 0, 65536, 65536, 16384, 0, 0, 65536);
    add_row(c, 1, passed(c, 0));
    // zero total mass with approaching velocity
    c = mk(-65536, 0, 0, 65536, 0, 0, 0, 0, 16384, 0, 0, 65536);
    add_row(c, 1, passed(c, 0));
    // both at rest with mass: impulse path with zero change
    c = mk(0, 0, 0, 0, 0, 0, 65536, 0, 0, 16384, 0, 0);
    add_row(c, 1, '{0, 0, 0, 0, 0, 0, 1'b1, 1'b0});
    // a at rest, b present: roles swap
    c = mk(0, 0, 0, 65536, -65536, 0, 65536, 65536, 0, 16384, 0, 32768);
    add_row(c, 0, '0);
    c = mk(0, 0, 0, -65536, 0, 0, 0, 65536, 16384, 0, 0, 0);
    add_row(c, 0, '0);
    // a at rest, b with mass only
    c = mk(0, 0, 0, 0, 0, 0, 65536, 65536, 0, 0, -16384, 65536);
    add_row(c, 0, '0);
    // head-on equal masses, e of 1.0
    c = mk(-65536, 0, 0, 0, 0, 0, 65536, 65536, 16384, 0, 0, 65536);
    add_row(c, 0, '0);
    // restitution above 1.0, largest
    c = mk(0, -131072, 0, 0, 0, 0, 65536, 0, 0, 16384, 0, 17'h1FFFF);
    add_row(c, 0, '0);
    // extremes that saturate
    c = mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
           16384, 16384, 16384, 17'h1FFFF);
    add_row(c, 0, '0);
    c = mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh8000_0000, 32'sh8000_0000, 1, 31'h7FFF_FFFF,
           -16384, -16384, -16384, 65536);
    add_row(c, 0, '0);
    // out-of-range normal components
    c = mk(12345, -999999, 777, -5, 8, 9, 300, 70000, 16'sh7FFF, 16'sh8000, 16'sh8000, 100);
    add_row(c, 0, '0);
    c = mk(-1, -1, -1, 1, 1, 1, 31'h7FFF_FFFF, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    add_row(c, 0, '0);
    // tiny masses, one side zero
    c = mk(-70000, 40000, 0, 3, 0, 0, 0, 1, 16384, -16384, 0, 1);
    add_row(c, 0, '0);
    // all bits of the masses and restitution toggled
    c = mk(-1234567, 7654321, -42, 99, -99, 100000, 31'h5555_5555, 31'h2AAA_AAAA,
           -11585, 11585, 0, 17'h15555);
    add_row(c, 0, '0);
  endtask

  // send one word, sender idles at random
  task automatic send_contact(contact_t c);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.vel_a_x  <= c.va_x; in_ch.vel_a_y <= c.va_y; in_ch.vel_a_z <= c.va_z;
    in_ch.vel_b_x  <= c.vb_x; in_ch.vel_b_y <= c.vb_y; in_ch.vel_b_z <= c.vb_z;
    in_ch.inv_mass_a <= c.ima; in_ch.inv_mass_b <= c.imb;
    in_ch.normal_x <= c.n_x; in_ch.normal_y <= c.n_y; in_ch.normal_z <= c.n_z;
    in_ch.bounce_factor <= c.e;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // expectation pushed at the accepting edge, ahead of any result
  contact_t  drv_word;
  bit        drv_fixed;
  resolved_t drv_fx;
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (drv_fixed) pending_velocities.push_back(drv_fx);
      else pending_velocities.push_back(resolve_contact(drv_word));
    end
  end

  task automatic drive(contact_t c, bit fixed_ok, resolved_t fx);
    drv_word = c; drv_fixed = fixed_ok; drv_fx = fx;
    send_contact(c);
  endtask

  // receiver stalls and result checks
  always @(negedge clk) begin
    out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    resolved_t got;
    resolved_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.new_a_x, out_ch.new_a_y, out_ch.new_a_z, out_ch.new_b_x,
              out_ch.new_b_y, out_ch.new_b_z, out_ch.impulse_applied,
              out_ch.roles_swapped};
      if (pending_velocities.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_velocities.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t mismatch a expected %0d %0d %0d actual %0d %0d %0d", $time,
                   want.a_x, want.a_y, want.a_z, got.a_x, got.a_y, got.a_z);
          $display("%0t mismatch b expected %0d %0d %0d actual %0d %0d %0d", $time,
                   want.b_x, want.b_y, want.b_z, got.b_x, got.b_y, got.b_z);
          $display("%0t flags expected applied %b swapped %b actual %b %b", $time,
                   want.applied, want.swapped, got.applied, got.swapped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("particle_contact_velocity_resolve_unit verification failed");
      $finish;
    end
  end

  initial begin
    int pct_send[4];
    int pct_recv[4];
    pct_send = '{0, 50, 0, 31};
    pct_recv = '{0, 0, 50, 31};
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drv_fixed      = 0;
    drv_word       = '0;
    drv_fx         = '0;
    rst_n          = 1'b0;
    in_ch.valid    <= 1'b0;
    {in_ch.vel_a_x, in_ch.vel_a_y, in_ch.vel_a_z} <= '0;
    {in_ch.vel_b_x, in_ch.vel_b_y, in_ch.vel_b_z} <= '0;
    in_ch.inv_mass_a <= '0; in_ch.inv_mass_b <= '0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z} <= '0;
    in_ch.bounce_factor <= '0;
    build_rows();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed_rows[i])
      drive(directed_rows[i].c, directed_rows[i].has_fixed, directed_rows[i].fixed);

    // random contacts over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < 185; i++) drive(rand_contact(), 0, '0);
      // after the sender-idle phase the sender holds off until the pipe drains
      if (ph == 1) begin
        in_ch.valid <= 1'b0;
        while (pending_velocities.size() != 0) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_velocities.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatch_count == 0 && pending_velocities.size() == 0) begin
      $display("particle_contact_velocity_resolve_unit verification clean");
    end else begin
      $display("particle_contact_velocity_resolve_unit verification failed");
    end
    $finish;
  end

endmodule
